FILE: src/assert_macros.svh
// Assertion macros shared by the text console cell writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/tcw_pkg.sv
// Package with the constants, types and helper functions of the text console cell writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;
    localparam int ADDR_W = $clog2(CELLS);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        K_PUT      = 3'd0,
        K_BS       = 3'd1,
        K_NL       = 3'd2,
        K_READ     = 3'd3,
        K_READ_OUT = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  read_column;
        logic [ROW_W-1:0]  read_row;
    } t_cmd;

    // Map a screen row to its row in the store, given the row that is on top.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W + 1)'(ROWS)) begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

endpackage

FILE: src/tcw_channels.sv
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps

interface tcw_in_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic [tcw_pkg::COL_W-1:0]  read_column;
    logic [tcw_pkg::ROW_W-1:0]  read_row;

    modport source(output valid, op, char_code, read_column, read_row, input ready);
    modport sink(input valid, op, char_code, read_column, read_row, output ready);
endinterface

interface tcw_out_if;
    logic                       valid;
    logic                       ready;
    logic [tcw_pkg::CHAR_W-1:0] cell_char;
    logic [tcw_pkg::CHAR_W-1:0] cell_color;
    logic [tcw_pkg::COL_W-1:0]  cursor_column;
    logic [tcw_pkg::ROW_W-1:0]  cursor_row;

    modport source(output valid, cell_char, cell_color, cursor_column, cursor_row,
                   input ready);
    modport sink(input valid, cell_char, cell_color, cursor_column, cursor_row,
                 output ready);
endinterface

interface tcw_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tcw_pkg::CHAR_W-1:0] text_color;

    modport source(output valid, text_color, input ready);
    modport sink(input valid, text_color, output ready);
endinterface

FILE: src/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/tcw_front.sv
// Front end: accepts input items, classifies them and hands commands to the queue.
`timescale 1ns / 1ps

module tcw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hold,
    tcw_in_if.sink        i_in,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output tcw_pkg::t_cmd o_push_cmd
);

    logic          r_valid;
    tcw_pkg::t_cmd r_cmd;
    tcw_pkg::t_cmd n_cmd;
    logic          take;
    logic          col_ok;
    logic          row_ok;

    assign i_in.ready = !i_hold && (!r_valid || i_push_ready);
    assign take       = i_in.valid && i_in.ready;

    assign col_ok = {1'b0, i_in.read_column} < (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS);
    assign row_ok = {1'b0, i_in.read_row} < (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS);

    always_comb begin
        n_cmd.char_code   = i_in.char_code;
        n_cmd.read_column = i_in.read_column;
        n_cmd.read_row    = i_in.read_row;
        if (i_in.op == tcw_pkg::OP_READ) begin
            n_cmd.kind = (col_ok && row_ok) ? tcw_pkg::K_READ : tcw_pkg::K_READ_OUT;
        end else if (i_in.char_code == tcw_pkg::CH_BACKSPACE) begin
            n_cmd.kind = tcw_pkg::K_BS;
        end else if (i_in.char_code == tcw_pkg::CH_NEWLINE) begin
            n_cmd.kind = tcw_pkg::K_NL;
        end else begin
            n_cmd.kind = tcw_pkg::K_PUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule

FILE: src/tcw_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tcw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  tcw_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output tcw_pkg::t_cmd o_pop_cmd
);

    tcw_pkg::t_cmd               r_slot [tcw_pkg::QDEPTH];
    logic [tcw_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [tcw_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [tcw_pkg::QCNT_W-1:0]  r_count;
    logic                        push;

    assign o_push_ready = r_count != tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign o_pop_cmd    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && (r_count == '0), "pop from empty queue")

endmodule

FILE: src/tcw_back.sv
// Back end: runs commands against the screen store, scrolls and drives the result register.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tcw_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    output logic                       o_q_pop,
    input  tcw_pkg::t_cmd              i_q_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0] i_text_color,
    output logic                       o_clearing,
    tcw_out_if.source                  o_out
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_ACCESS = 6'b000100,
        S_RDWAIT = 6'b001000,
        S_SCROLL = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [tcw_pkg::COL_W-1:0]   r_col_cur, n_col_cur;
    logic [tcw_pkg::ROW_W-1:0]   r_line, n_line;
    logic [tcw_pkg::ROW_W-1:0]   r_top, n_top;
    logic [tcw_pkg::ROW_W-1:0]   r_prow, n_prow;
    logic [tcw_pkg::COL_W-1:0]   r_col, n_col;
    logic                        r_is_read, n_is_read;
    logic                        r_nl_pend, n_nl_pend;
    logic [tcw_pkg::CELL_W-1:0]  r_wdata, n_wdata;
    logic [tcw_pkg::CHAR_W-1:0]  r_res_char, n_res_char;
    logic [tcw_pkg::CHAR_W-1:0]  r_res_color, n_res_color;
    logic [tcw_pkg::ADDR_W-1:0]  r_clr_addr, n_clr_addr;

    logic                        r_out_valid;
    logic [tcw_pkg::CHAR_W-1:0]  r_out_char;
    logic [tcw_pkg::CHAR_W-1:0]  r_out_color;
    logic [tcw_pkg::COL_W-1:0]   r_out_col;
    logic [tcw_pkg::ROW_W-1:0]   r_out_row;

    logic                        out_load;
    logic                        do_nl;
    logic                        ram_we;
    logic                        ram_re;
    logic [tcw_pkg::ADDR_W-1:0]  ram_addr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;
    logic [tcw_pkg::ADDR_W-1:0]  acc_addr;

    // Store address of the row and column held for the current access.
    assign acc_addr = tcw_pkg::ADDR_W'(r_prow) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                    + tcw_pkg::ADDR_W'(r_col);

    always_comb begin
        n_state     = r_state;
        n_col_cur   = r_col_cur;
        n_line      = r_line;
        n_top       = r_top;
        n_prow      = r_prow;
        n_col       = r_col;
        n_is_read   = r_is_read;
        n_nl_pend   = r_nl_pend;
        n_wdata     = r_wdata;
        n_res_char  = r_res_char;
        n_res_color = r_res_color;
        n_clr_addr  = r_clr_addr;
        o_q_pop     = 1'b0;
        out_load    = 1'b0;
        do_nl       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = acc_addr;
        ram_wdata   = r_wdata;

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                ram_wdata  = tcw_pkg::BLANK_CELL;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == tcw_pkg::LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop     = 1'b1;
                    n_res_char  = '0;
                    n_res_color = '0;
                    n_nl_pend   = 1'b0;
                    n_is_read   = 1'b0;
                    case (i_q_cmd.kind)
                        tcw_pkg::K_READ: begin
                            n_is_read = 1'b1;
                            n_col     = i_q_cmd.read_column;
                            n_prow    = tcw_pkg::phys_row(i_q_cmd.read_row, r_top);
                            n_state   = S_ACCESS;
                        end
                        tcw_pkg::K_BS: begin
                            if (r_col_cur != '0) begin
                                n_col_cur = r_col_cur - 1'b1;
                                n_col     = r_col_cur - 1'b1;
                                n_prow    = tcw_pkg::phys_row(r_line, r_top);
                                n_wdata   = {i_text_color, tcw_pkg::CH_SPACE};
                                n_state   = S_ACCESS;
                            end else begin
                                n_state = S_RESULT;
                            end
                        end
                        tcw_pkg::K_NL: begin
                            do_nl = 1'b1;
                        end
                        tcw_pkg::K_PUT: begin
                            n_col   = r_col_cur;
                            n_prow  = tcw_pkg::phys_row(r_line, r_top);
                            n_wdata = {i_text_color, i_q_cmd.char_code};
                            if (r_col_cur == tcw_pkg::LAST_COL) begin
                                n_nl_pend = 1'b1;
                            end else begin
                                n_col_cur = r_col_cur + 1'b1;
                            end
                            n_state = S_ACCESS;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_ACCESS: begin
                if (r_is_read) begin
                    ram_re  = 1'b1;
                    n_state = S_RDWAIT;
                end else begin
                    ram_we = 1'b1;
                    if (r_nl_pend) begin
                        do_nl = 1'b1;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_RDWAIT: begin
                n_res_char  = ram_rdata[tcw_pkg::CHAR_W-1:0];
                n_res_color = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                n_state     = S_RESULT;
            end
            S_SCROLL: begin
                ram_we = 1'b1;
                n_col  = r_col + 1'b1;
                if (r_col == tcw_pkg::LAST_COL) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // Line feed: past the bottom row the top row rotates and its old
        // storage row becomes the new, blank bottom row.
        if (do_nl) begin
            n_col_cur = '0;
            if (r_line == tcw_pkg::LAST_ROW) begin
                n_prow  = r_top;
                n_col   = '0;
                n_top   = (r_top == tcw_pkg::LAST_ROW) ? '0 : r_top + 1'b1;
                n_wdata = {i_text_color, tcw_pkg::CH_SPACE};
                n_state = S_SCROLL;
            end else begin
                n_line  = r_line + 1'b1;
                n_state = S_RESULT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_col_cur   <= '0;
            r_line      <= '0;
            r_top       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col_cur  <= n_col_cur;
            r_line     <= n_line;
            r_top      <= n_top;
            r_clr_addr <= n_clr_addr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prow      <= n_prow;
        r_col       <= n_col;
        r_is_read   <= n_is_read;
        r_nl_pend   <= n_nl_pend;
        r_wdata     <= n_wdata;
        r_res_char  <= n_res_char;
        r_res_color <= n_res_color;
        if (out_load) begin
            r_out_char  <= r_res_char;
            r_out_color <= r_res_color;
            r_out_col   <= r_col_cur;
            r_out_row   <= r_line;
        end
    end

    tcw_ram #(
        .WIDTH(tcw_pkg::CELL_W),
        .DEPTH(tcw_pkg::CELLS)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_addr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_addr),
        .o_rdata(ram_rdata)
    );

    assign o_clearing          = r_state == S_CLEAR;
    assign o_out.valid         = r_out_valid;
    assign o_out.cell_char     = r_out_char;
    assign o_out.cell_color    = r_out_color;
    assign o_out.cursor_column = r_out_col;
    assign o_out.cursor_row    = r_out_row;

    `ASSERT_NEVER(a_cursor_range, i_clk, i_rst_n, (r_col_cur > tcw_pkg::LAST_COL) || (r_line > tcw_pkg::LAST_ROW) || (r_top > tcw_pkg::LAST_ROW), "cursor or top row off screen")
    `ASSERT_HOLDS(a_scroll_bottom, i_clk, i_rst_n, (r_state == S_SCROLL) |-> ((r_line == tcw_pkg::LAST_ROW) && (r_col_cur == '0)), "scroll with cursor off bottom row")
    `ASSERT_HOLDS(a_no_result_clear, i_clk, i_rst_n, (r_state == S_CLEAR) |-> (!r_out_valid && !o_q_pop), "activity during clearing pass")

endmodule

FILE: src/text_console_cell_writer_top.sv
// Top level of the text console cell writer: front end, command queue, back end, color register.
//
//  channel  direction  payload                                          transfer when
//  i_in     in         op, char_code, read_column, read_row             valid && ready
//  o_out    out        cell_char, cell_color, cursor_column, cursor_row valid && ready
//  i_cfg    in         text_color                                       valid && ready
//
// A read of an on-screen cell passes through the back-end states ACCESS, RDWAIT and RESULT,
// a put or a backspace that moves the cursor through ACCESS and RESULT, and a newline, an
// off-screen read or a backspace at column zero straight to RESULT. A line feed past the
// bottom row, from a newline or a wrap, adds a SCROLL pass that blanks the new bottom row.
// After reset the screen store is swept once, all COLUMNS * ROWS cells (2000), with i_in held off.
// The front register and a two-entry queue keep taking items while the back end is busy,
// and the result register lets the next item proceed while a result waits on o_out.
`timescale 1ns / 1ps

module text_console_cell_writer_top (
    input logic       i_clk,
    input logic       i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_out_if.source o_out,
    tcw_cfg_if.sink   i_cfg
);

    // Color byte applied to every newly written or blanked cell; the reset sweep uses BLANK_CELL.
    logic [tcw_pkg::CHAR_W-1:0] r_text_color;

    logic          push_valid;
    logic          push_ready;
    tcw_pkg::t_cmd push_cmd;
    logic          pop_valid;
    logic          pop;
    tcw_pkg::t_cmd pop_cmd;
    logic          clearing;

    // Always ready; the user must write the register only while the block is idle (unenforced).
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= 8'h07;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_text_color <= i_cfg.text_color;
        end
    end

    // Front end: classifies items into commands; held off during the reset sweep.
    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_in        (i_in),
        .o_push_valid(push_valid),
        .i_push_ready(push_ready),
        .o_push_cmd  (push_cmd)
    );

    // Command queue so the front and back ends stall independently.
    tcw_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(push_valid),
        .o_push_ready(push_ready),
        .i_push_cmd  (push_cmd),
        .o_pop_valid (pop_valid),
        .i_pop       (pop),
        .o_pop_cmd   (pop_cmd)
    );

    // Back end: owns the cursor, the rotating top row and the screen store.
    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (pop_valid),
        .o_q_pop     (pop),
        .i_q_cmd     (pop_cmd),
        .i_text_color(r_text_color),
        .o_clearing  (clearing),
        .o_out       (o_out)
    );

endmodule

FILE: tb/text_console_cell_writer_top_tb.sv
// Self-checking testbench for the text console cell writer: random text with control codes and reads.
`timescale 1ns / 1ps

module text_console_cell_writer_top_tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 150;   // covers a bottom-row blanking pass plus the pipeline
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 150;
    localparam int PRINT_CAP     = 40;

    // One console command as it goes onto the input channel.
    typedef struct packed {
        logic                       op;
        logic [tcw_pkg::CHAR_W-1:0] char_code;
        logic [tcw_pkg::COL_W-1:0]  read_column;
        logic [tcw_pkg::ROW_W-1:0]  read_row;
    } t_console_item;

    // One console response: cell contents and cursor position.
    typedef struct packed {
        logic [tcw_pkg::CHAR_W-1:0] cell_char;
        logic [tcw_pkg::CHAR_W-1:0] cell_color;
        logic [tcw_pkg::COL_W-1:0]  cursor_column;
        logic [tcw_pkg::ROW_W-1:0]  cursor_row;
    } t_cell_result;

    logic i_clk;
    logic i_rst_n;

    tcw_in_if  in_if ();
    tcw_out_if out_if ();
    tcw_cfg_if cfg_if ();

    text_console_cell_writer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the console: screen, cursor and color register.
    logic [tcw_pkg::CELL_W-1:0] screen_model [0:tcw_pkg::CELLS-1];
    logic [tcw_pkg::COL_W-1:0]  cursor_col_model;
    logic [tcw_pkg::ROW_W-1:0]  cursor_row_model;
    logic [tcw_pkg::CHAR_W-1:0] color_model;

    t_console_item pending_items [$];
    t_cell_result  expected_cells [$];
    t_console_item item_on_wire;

    bit idle_on;
    int hold_req;
    int hold_seen;
    int hold_left;
    int gap_left;
    int stall_left;
    int cycle_count;
    int err_count;
    int results_seen;
    int items_accepted;
    int reads_done;
    int scrolls_done;
    int wraps_done;
    int color_writes;
    int phase_pushed;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("MISMATCH at result %0d: %s", results_seen, msg);
        end
        err_count++;
    endtask

    // Line feed: column zero of the next row, scrolling the screen up past the bottom row.
    function automatic void line_feed();
        cursor_col_model = '0;
        if (cursor_row_model == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
            for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++) begin
                screen_model[i] = screen_model[i + tcw_pkg::COLUMNS];
            end
            for (int i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++) begin
                screen_model[i] = {color_model, tcw_pkg::CH_SPACE};
            end
            scrolls_done++;
        end else begin
            cursor_row_model = cursor_row_model + 1'b1;
        end
    endfunction

    function automatic t_cell_result console_step(input t_console_item it);
        t_cell_result               res;
        logic [tcw_pkg::CELL_W-1:0] cell_word;
        int                         pos;
        res = '0;
        pos = int'(cursor_row_model) * tcw_pkg::COLUMNS + int'(cursor_col_model);
        if (it.op == tcw_pkg::OP_READ) begin
            reads_done++;
            if (int'(it.read_column) < tcw_pkg::COLUMNS && int'(it.read_row) < tcw_pkg::ROWS) begin
                cell_word = screen_model[int'(it.read_row) * tcw_pkg::COLUMNS
                                         + int'(it.read_column)];
                res.cell_char  = cell_word[7:0];
                res.cell_color = cell_word[15:8];
            end
        end else if (it.char_code == tcw_pkg::CH_BACKSPACE) begin
            if (cursor_col_model != 0) begin
                cursor_col_model = cursor_col_model - 1'b1;
                screen_model[pos - 1] = {color_model, tcw_pkg::CH_SPACE};
            end
        end else if (it.char_code == tcw_pkg::CH_NEWLINE) begin
            line_feed();
        end else begin
            screen_model[pos] = {color_model, it.char_code};
            cursor_col_model = cursor_col_model + 1'b1;
            if (int'(cursor_col_model) >= tcw_pkg::COLUMNS) begin
                wraps_done++;
                line_feed();
            end
        end
        res.cursor_column = cursor_col_model;
        res.cursor_row    = cursor_row_model;
        return res;
    endfunction

    // Driver: offers pending commands, with random gaps while idling is enabled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_cells.push_back(console_step(item_on_wire));
                items_accepted++;
            end
            if (in_if.valid && !in_if.ready) begin
                // Offer stays on the wire until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_items.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 17) - 1;
                in_if.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                item_on_wire = pending_items.pop_front();
                in_if.valid       <= 1'b1;
                in_if.op          <= item_on_wire.op;
                in_if.char_code   <= item_on_wire.char_code;
                in_if.read_column <= item_on_wire.read_column;
                in_if.read_row    <= item_on_wire.read_row;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks every result transfer and applies back-pressure on the output.
    always @(posedge i_clk) begin
        t_cell_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left  = 0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_cells.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = expected_cells.pop_front();
                    if (out_if.cell_char !== want.cell_char) begin
                        report_mismatch($sformatf("cell_char got %0h expected %0h",
                                                  out_if.cell_char, want.cell_char));
                    end
                    if (out_if.cell_color !== want.cell_color) begin
                        report_mismatch($sformatf("cell_color got %0h expected %0h",
                                                  out_if.cell_color, want.cell_color));
                    end
                    if (out_if.cursor_column !== want.cursor_column) begin
                        report_mismatch($sformatf("cursor_column got %0d expected %0d",
                                                  out_if.cursor_column, want.cursor_column));
                    end
                    if (out_if.cursor_row !== want.cursor_row) begin
                        report_mismatch($sformatf("cursor_row got %0d expected %0d",
                                                  out_if.cursor_row, want.cursor_row));
                    end
                end
                results_seen++;
            end
            if (hold_seen != hold_req) begin
                // Long hold-off so the input side backs up and stalls.
                hold_seen = hold_req;
                hold_left = LONG_HOLD - 1;
                out_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_cells.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_item(input logic op, input logic [tcw_pkg::CHAR_W-1:0] ch,
                             input logic [tcw_pkg::COL_W-1:0] col,
                             input logic [tcw_pkg::ROW_W-1:0] row);
        t_console_item it;
        it.op          = op;
        it.char_code   = ch;
        it.read_column = col;
        it.read_row    = row;
        pending_items.push_back(it);
        phase_pushed++;
    endtask

    function automatic logic [tcw_pkg::CHAR_W-1:0] text_char();
        logic [tcw_pkg::CHAR_W-1:0] ch;
        if ($urandom_range(0, 3) != 0) begin
            ch = tcw_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E));
        end else begin
            do begin
                ch = tcw_pkg::CHAR_W'($urandom_range(0, 255));
            end while (ch == tcw_pkg::CH_BACKSPACE || ch == tcw_pkg::CH_NEWLINE);
        end
        return ch;
    endfunction

    task automatic push_read();
        if ($urandom_range(0, 6) != 0) begin
            push_item(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom),
                      tcw_pkg::COL_W'($urandom_range(0, tcw_pkg::COLUMNS - 1)),
                      tcw_pkg::ROW_W'($urandom_range(0, tcw_pkg::ROWS - 1)));
        end else begin
            push_item(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom),
                      tcw_pkg::COL_W'($urandom_range(0, 127)),
                      tcw_pkg::ROW_W'($urandom_range(0, 31)));
        end
    endtask

    // Mostly lines of text with reads and backspaces mixed in; the rest is runs of blank lines and raw noise.
    task automatic fill_random_phase(input int count);
        int len;
        int sel;
        phase_pushed = 0;
        while (phase_pushed < count) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(75, 170)
                                                  : $urandom_range(0, 18);
                for (int i = 0; i < len && phase_pushed < count; i++) begin
                    sel = $urandom_range(0, 19);
                    if (sel == 0) begin
                        push_item(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE,
                                  tcw_pkg::COL_W'($urandom), tcw_pkg::ROW_W'($urandom));
                    end else if (sel <= 4) begin
                        push_read();
                    end else begin
                        push_item(tcw_pkg::OP_PUT, text_char(),
                                  tcw_pkg::COL_W'($urandom), tcw_pkg::ROW_W'($urandom));
                    end
                end
                if ($urandom_range(0, 4) != 0) begin
                    push_item(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE,
                              tcw_pkg::COL_W'($urandom), tcw_pkg::ROW_W'($urandom));
                end
            end else if (sel == 7) begin
                // A run of blank lines pushes the cursor toward the bottom and scrolls.
                repeat ($urandom_range(1, 8)) begin
                    push_item(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE,
                              tcw_pkg::COL_W'($urandom), tcw_pkg::ROW_W'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    push_item(1'($urandom), tcw_pkg::CHAR_W'($urandom),
                              tcw_pkg::COL_W'($urandom), tcw_pkg::ROW_W'($urandom));
                end
            end
        end
    endtask

    // Sender pause: nothing queued, nothing on the wire, every result back, then settle.
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_if.valid || expected_cells.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_text_color(input logic [tcw_pkg::CHAR_W-1:0] color);
        @(posedge i_clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.text_color <= color;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        color_model = color;
        color_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        logic [tcw_pkg::CHAR_W-1:0] phase_colors [6];

        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.op          = tcw_pkg::OP_PUT;
        in_if.char_code   = '0;
        in_if.read_column = '0;
        in_if.read_row    = '0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.text_color = '0;
        for (int i = 0; i < tcw_pkg::CELLS; i++) begin
            screen_model[i] = tcw_pkg::BLANK_CELL;
        end
        cursor_col_model = '0;
        cursor_row_model = '0;
        color_model      = 8'h07;
        idle_on          = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset color: blank screen, reads off the screen,
        // backspace at column zero, extreme characters, backspace blanking, newline.
        push_item(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd0);
        push_item(tcw_pkg::OP_READ, 8'hFF, tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1),
                  tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
        push_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::COL_W'(tcw_pkg::COLUMNS), 5'd0);
        push_item(tcw_pkg::OP_READ, 8'h00, 7'h7F, 5'h1F);
        push_item(tcw_pkg::OP_READ, 8'h00, 7'd0, tcw_pkg::ROW_W'(tcw_pkg::ROWS));
        push_item(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 7'h7F, 5'h1F);
        push_item(tcw_pkg::OP_PUT, 8'h41, 7'd0, 5'd0);
        push_item(tcw_pkg::OP_PUT, 8'h00, 7'd0, 5'd0);
        push_item(tcw_pkg::OP_PUT, 8'hFF, 7'h7F, 5'h1F);
        push_item(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0);
        push_item(tcw_pkg::OP_READ, 8'h00, 7'd2, 5'd0);
        push_item(tcw_pkg::OP_READ, 8'h00, 7'd1, 5'd0);
        push_item(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0);
        push_item(tcw_pkg::OP_PUT, tcw_pkg::CH_SPACE, 7'd0, 5'd0);
        push_item(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd1);
        wait_drained();

        // Directed part with the brightest color.
        set_text_color(8'hFF);
        push_item(tcw_pkg::OP_PUT, 8'h7E, 7'd0, 5'd0);
        push_item(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0);
        push_item(tcw_pkg::OP_READ, 8'h00, 7'd1, 5'd1);
        push_item(tcw_pkg::OP_PUT, 8'h5A, 7'd0, 5'd0);
        push_item(tcw_pkg::OP_READ, 8'hFF, 7'd1, 5'd1);
        push_item(tcw_pkg::OP_READ, 8'h00, 7'd64, 5'd16);
        push_item(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0);
        wait_drained();

        phase_colors[0] = 8'h00;
        phase_colors[1] = tcw_pkg::CHAR_W'($urandom);
        phase_colors[2] = tcw_pkg::CHAR_W'($urandom);
        phase_colors[3] = 8'hF0;
        phase_colors[4] = tcw_pkg::CHAR_W'($urandom);
        phase_colors[5] = 8'h0F;

        for (int p = 0; p < 6; p++) begin
            set_text_color(phase_colors[p]);
            // The last phase runs flat out on both sides.
            idle_on = (p != 5);
            if (p == 2) begin
                hold_req++;
            end
            fill_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (expected_cells.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_cells.size()));
        end

        $display("Covered %0d commands (%0d reads) and %0d results over %0d color settings",
                 items_accepted, reads_done, results_seen, color_writes + 1);
        $display("Cursor wrapped %0d times and the screen scrolled %0d times; %0d mismatches",
                 wraps_done, scrolls_done, err_count);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/tcw_pkg.sv
src/tcw_channels.sv
src/tcw_ram.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_cell_writer_top.sv
tb/text_console_cell_writer_top_tb.sv
